// File: hw/rtl/tstt_pkg.sv
`timescale 1ns / 1ps

package tstt_pkg;

    localparam int unsigned BUCKET_COUNT = 65536;
    localparam int unsigned BUCKET_BITS  = $clog2(BUCKET_COUNT);

    localparam int unsigned S_DATA_W = 192;
    localparam int unsigned M_DATA_W = 56;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    // packed as upper [56:36], lower [35:15], col [14:11], row [10:7], depth [6:0]
    typedef struct packed {
        logic signed [20:0] upper;
        logic signed [20:0] lower;
        logic signed [3:0]  col;
        logic signed [3:0]  row;
        logic [6:0]         depth;
    } info_t;

    typedef struct packed {
        logic [63:0] new_lock;
        info_t       new_info;
        logic [63:0] deep_lock;
        info_t       deep_info;
    } bucket_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [BUCKET_BITS-1:0] bucket;
        logic [63:0]            lock;
        info_t                  info;
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CALC  = 3'b100
    } state_t;

endpackage

// File: hw/rtl/two_slot_transposition_table_core.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake         | Payload
// s_       | in  | s_tvalid/s_tready | s_tuser cmd, s_tdata key, lock, depth, bounds, move
// m_       | out | m_tvalid/m_tready | m_tuser hit, m_tdata bounds, move
//
// Each request is handled as a registered read of the bucket memory, then a
// compare step; an update also merges and writes the bucket row back.
// After aresetn the bucket memory is cleared one row a cycle, all 65536 rows,
// with s_tready low.
// A finished response sits in the output register; the next request is taken
// meanwhile and waits in its compare cycle until the output register frees.

module two_slot_transposition_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // bucket_key [63:0], lock_key [127:64], search_depth [134:128],
    // lower_in [155:135], upper_in [176:156], move_row_in [180:177],
    // move_col_in [184:181], zero [191:185]
    input  logic [tstt_pkg::S_DATA_W-1:0] s_tdata,
    // cmd [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // lower_out [20:0], upper_out [41:21], move_row_out [45:42],
    // move_col_out [49:46], zero [55:50]
    output logic [tstt_pkg::M_DATA_W-1:0] m_tdata,
    // hit [0]
    output logic                          m_tuser
);
    import tstt_pkg::*;

    bucket_t                mem [BUCKET_COUNT];
    bucket_t                rdata_reg;

    state_t                 state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    req_t                   req_reg;

    logic                   m_valid_reg, m_valid_next;
    logic                   hit_reg, hit_next;
    info_t                  out_reg, out_next;

    logic                   accept;
    logic                   out_free;
    logic                   wr_en;
    logic [BUCKET_BITS-1:0] wr_addr;
    bucket_t                wr_data;
    bucket_t                upd_row;

    logic                   dm, nm;
    info_t                  fresh, merged_src, merged, miss;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // bucket memory
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= mem[s_tdata[BUCKET_BITS-1:0]];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.cmd        <= cmd_t'(s_tuser);
            req_reg.bucket     <= s_tdata[BUCKET_BITS-1:0];
            req_reg.lock       <= s_tdata[127:64];
            req_reg.info.depth <= s_tdata[134:128];
            req_reg.info.lower <= s_tdata[155:135];
            req_reg.info.upper <= s_tdata[176:156];
            req_reg.info.row   <= s_tdata[180:177];
            req_reg.info.col   <= s_tdata[184:181];
        end
    end

    always_comb begin
        dm = (rdata_reg.deep_info.depth != 7'd0)
          && (rdata_reg.deep_info.depth == req_reg.info.depth)
          && (rdata_reg.deep_lock == req_reg.lock);
        nm = (rdata_reg.new_info.depth != 7'd0)
          && (rdata_reg.new_info.depth == req_reg.info.depth)
          && (rdata_reg.new_lock == req_reg.lock);

        fresh = req_reg.info;

        miss       = '0;
        miss.row   = 4'sb1111;
        miss.col   = 4'sb1111;

        merged_src = dm ? rdata_reg.deep_info : rdata_reg.new_info;
        merged       = merged_src;
        merged.lower = ($signed(req_reg.info.lower) > $signed(merged_src.lower))
                     ? req_reg.info.lower : merged_src.lower;
        merged.upper = ($signed(req_reg.info.upper) < $signed(merged_src.upper))
                     ? req_reg.info.upper : merged_src.upper;
        merged.row   = req_reg.info.row;
        merged.col   = req_reg.info.col;

        upd_row = rdata_reg;
        priority if (dm) begin
            upd_row.deep_info = merged;
        end else if (nm) begin
            upd_row.new_info = merged;
        end else if (req_reg.info.depth > rdata_reg.deep_info.depth) begin
            upd_row.new_lock  = rdata_reg.deep_lock;
            upd_row.new_info  = rdata_reg.deep_info;
            upd_row.deep_lock = req_reg.lock;
            upd_row.deep_info = fresh;
        end else begin
            upd_row.new_lock = req_reg.lock;
            upd_row.new_info = fresh;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        hit_next     = hit_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_addr      = req_reg.bucket;
        wr_data      = upd_row;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (req_reg.cmd == CMD_LOOKUP) begin
                        hit_next = dm || nm;
                        out_next = dm ? rdata_reg.deep_info
                                 : (nm ? rdata_reg.new_info : miss);
                    end else begin
                        wr_en    = 1'b1;
                        hit_next = dm || nm;
                        out_next = (dm || nm) ? merged : fresh;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= hit_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {6'd0, out_reg.col, out_reg.row, out_reg.upper, out_reg.lower};

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request taken during memory clear");

    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CALC))
        else $error("accepted request did not reach compare cycle");

    a_no_write_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && m_valid_reg && !m_tready) |-> !wr_en)
        else $error("bucket written while response blocked");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && (&clr_cnt_reg)) |=> (state_reg == ST_IDLE))
        else $error("memory clear did not finish");

    a_response_follows_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && out_free) |=> m_valid_reg)
        else $error("response missing after compare cycle");

endmodule

// File: dv/tb_two_slot_transposition_table_core.sv
`timescale 1ns / 1ps

module tb_two_slot_transposition_table_core;
    import tstt_pkg::*;

    localparam int unsigned STALL_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct {
        cmd_t               cmd;
        logic [63:0]        key;
        logic [63:0]        lock;
        logic [6:0]         depth;
        logic signed [20:0] lo;
        logic signed [20:0] up;
        logic signed [3:0]  row;
        logic signed [3:0]  col;
    } probe_t;

    typedef struct packed {
        logic               hit;
        logic signed [20:0] lower;
        logic signed [20:0] upper;
        logic signed [3:0]  row;
        logic signed [3:0]  col;
    } reply_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    two_slot_transposition_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // table mirror
    logic [63:0] deep_lock_tab [BUCKET_COUNT];
    info_t       deep_info_tab [BUCKET_COUNT];
    logic [63:0] new_lock_tab  [BUCKET_COUNT];
    info_t       new_info_tab  [BUCKET_COUNT];

    probe_t      pending_probes[$];
    reply_t      expected_replies[$];
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned snd_idle_pct = 8;
    int unsigned rcv_idle_pct = 45;
    logic        hold_req     = 1'b0;
    logic        hold_done    = 1'b0;
    int unsigned hold_cnt     = 0;

    logic [BUCKET_BITS-1:0] bucket_pool [6];
    logic [63:0]            lock_pool   [6];
    logic [6:0]             depth_pool  [6];

    function automatic reply_t to_reply(logic hit, info_t info);
        reply_t r;
        r.hit   = hit;
        r.lower = info.lower;
        r.upper = info.upper;
        r.row   = info.row;
        r.col   = info.col;
        return r;
    endfunction

    function automatic info_t merge_bounds(info_t old, info_t fresh);
        info_t m;
        m       = old;
        m.lower = (fresh.lower > old.lower) ? fresh.lower : old.lower;
        m.upper = (fresh.upper < old.upper) ? fresh.upper : old.upper;
        m.row   = fresh.row;
        m.col   = fresh.col;
        return m;
    endfunction

    function automatic reply_t predict_probe(cmd_t cmd, logic [63:0] key, logic [63:0] lock,
                                             logic [6:0] depth, logic signed [20:0] lo,
                                             logic signed [20:0] up, logic signed [3:0] row,
                                             logic signed [3:0] col);
        int unsigned b;
        logic        deep_hit;
        logic        new_hit;
        info_t       fresh;
        info_t       empty;
        b        = key[BUCKET_BITS-1:0];
        deep_hit = deep_info_tab[b].depth != 0 && deep_info_tab[b].depth == depth
                   && deep_lock_tab[b] == lock;
        new_hit  = new_info_tab[b].depth != 0 && new_info_tab[b].depth == depth
                   && new_lock_tab[b] == lock;
        fresh    = '{upper: up, lower: lo, col: col, row: row, depth: depth};
        empty    = '{upper: '0, lower: '0, col: -4'sd1, row: -4'sd1, depth: '0};
        if (cmd == CMD_LOOKUP) begin
            if (deep_hit)
                return to_reply(1'b1, deep_info_tab[b]);
            if (new_hit)
                return to_reply(1'b1, new_info_tab[b]);
            return to_reply(1'b0, empty);
        end
        if (deep_hit) begin
            deep_info_tab[b] = merge_bounds(deep_info_tab[b], fresh);
            return to_reply(1'b1, deep_info_tab[b]);
        end
        if (new_hit) begin
            new_info_tab[b] = merge_bounds(new_info_tab[b], fresh);
            return to_reply(1'b1, new_info_tab[b]);
        end
        if (depth > deep_info_tab[b].depth) begin
            new_lock_tab[b]  = deep_lock_tab[b];
            new_info_tab[b]  = deep_info_tab[b];
            deep_lock_tab[b] = lock;
            deep_info_tab[b] = fresh;
        end else begin
            new_lock_tab[b] = lock;
            new_info_tab[b] = fresh;
        end
        return to_reply(1'b0, fresh);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_probes.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                probe_t p;
                p = pending_probes.pop_front();
                s_tdata  <= {7'b0, p.col, p.row, p.up, p.lo, p.depth, p.lock, p.key};
                s_tuser  <= p.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES)
                hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_replies.push_back(predict_probe(cmd_t'(s_tuser), s_tdata[63:0],
                s_tdata[127:64], s_tdata[134:128], s_tdata[155:135], s_tdata[176:156],
                s_tdata[180:177], s_tdata[184:181]));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: hit %0b", m_tuser);
                mismatches++;
            end else begin
                reply_t e;
                e = expected_replies.pop_front();
                if (m_tuser !== e.hit) begin
                    $error("hit: expected %0b, got %0b", e.hit, m_tuser);
                    mismatches++;
                end
                if ($signed(m_tdata[20:0]) !== e.lower) begin
                    $error("lower_out: expected %0d, got %0d", e.lower,
                           $signed(m_tdata[20:0]));
                    mismatches++;
                end
                if ($signed(m_tdata[41:21]) !== e.upper) begin
                    $error("upper_out: expected %0d, got %0d", e.upper,
                           $signed(m_tdata[41:21]));
                    mismatches++;
                end
                if ($signed(m_tdata[45:42]) !== e.row) begin
                    $error("move_row_out: expected %0d, got %0d", e.row,
                           $signed(m_tdata[45:42]));
                    mismatches++;
                end
                if ($signed(m_tdata[49:46]) !== e.col) begin
                    $error("move_col_out: expected %0d, got %0d", e.col,
                           $signed(m_tdata[49:46]));
                    mismatches++;
                end
            end
        end
    end

    // watchdog; covers the memory clear after reset
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_probe(cmd_t cmd, logic [63:0] key, logic [63:0] lock,
                              int depth, int lo, int up, int row, int col);
        probe_t p;
        p = '{cmd: cmd, key: key, lock: lock, depth: 7'(depth), lo: 21'(lo), up: 21'(up),
              row: 4'(row), col: 4'(col)};
        pending_probes.push_back(p);
    endtask

    function automatic logic signed [20:0] rand_score();
        case ($urandom_range(5))
            0: return -21'sd1000000;
            1: return 21'sd1000000;
            2: return '0;
            default: return 21'(int'($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic probe_t random_probe();
        probe_t p;
        p.cmd  = cmd_t'($urandom_range(1));
        p.key  = {$urandom, $urandom};
        p.lock = {$urandom, $urandom};
        if ($urandom_range(9) != 0)
            p.key[BUCKET_BITS-1:0] = bucket_pool[$urandom_range(5)];
        if ($urandom_range(99) < 85)
            p.lock = lock_pool[$urandom_range(5)];
        p.depth = ($urandom_range(9) < 8) ? depth_pool[$urandom_range(5)]
                                          : 7'($urandom_range(127));
        p.lo  = rand_score();
        p.up  = rand_score();
        p.row = 4'(int'($urandom_range(8)) - 1);
        p.col = 4'(int'($urandom_range(8)) - 1);
        return p;
    endfunction

    // mostly short runs of requests on one position, the rest scattered
    task automatic queue_random(int unsigned count);
        int unsigned made;
        int unsigned run;
        probe_t      p;
        probe_t      q;
        made = 0;
        while (made < count) begin
            p = random_probe();
            if ($urandom_range(99) < 70) begin
                run = $urandom_range(4, 2);
                repeat (run) begin
                    q       = random_probe();
                    q.key   = p.key;
                    q.lock  = p.lock;
                    q.depth = p.depth;
                    pending_probes.push_back(q);
                    made++;
                end
            end else begin
                pending_probes.push_back(p);
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_probes.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        logic [63:0] ones;
        logic [63:0] lk_a;
        logic [63:0] lk_b;
        logic [63:0] lk_c;
        ones = '1;
        lk_a = {$urandom, $urandom};
        lk_b = {$urandom, $urandom};
        lk_c = {$urandom, $urandom};
        for (int i = 0; i < BUCKET_COUNT; i++) begin
            deep_lock_tab[i] = '0;
            deep_info_tab[i] = '0;
            new_lock_tab[i]  = '0;
            new_info_tab[i]  = '0;
        end
        bucket_pool = '{'0, '1, BUCKET_BITS'(1), BUCKET_BITS'(16'h8000),
                        BUCKET_BITS'($urandom), BUCKET_BITS'($urandom)};
        lock_pool   = '{'0, '1, lk_a, lk_b, {$urandom, $urandom}, {$urandom, $urandom}};
        depth_pool  = '{7'd0, 7'd1, 7'd2, 7'd7, 7'd64, 7'd127};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty slots, hits, misses, merge, depth zero, replacement
        push_probe(CMD_LOOKUP, '0, '0, 0, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, '0, '0, 127, -21'sd1000000, 21'sd1000000, -1, 7);
        push_probe(CMD_LOOKUP, '0, '0, 127, 0, 0, 0, 0);
        push_probe(CMD_LOOKUP, '0, '0, 126, 0, 0, 0, 0);
        push_probe(CMD_LOOKUP, '0, ones, 127, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, {48'hffff_0000_1234, 16'h0}, '0, 127, 500, -300, 7, -1);
        push_probe(CMD_UPDATE, '0, '0, 127, -900, 900, 0, 0);
        push_probe(CMD_LOOKUP, '0, '0, 127, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, '0, ones, 0, 21'sd1000000, -21'sd1000000, 3, 4);
        push_probe(CMD_LOOKUP, '0, ones, 0, 0, 0, 0, 0);
        push_probe(CMD_LOOKUP, '0, '0, 0, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, ones, lk_a, 5, 10, 20, 1, 2);
        push_probe(CMD_UPDATE, ones, lk_b, 9, 30, 40, 3, 4);
        push_probe(CMD_LOOKUP, ones, lk_a, 5, 0, 0, 0, 0);
        push_probe(CMD_LOOKUP, ones, lk_b, 9, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, ones, lk_c, 3, 50, 60, 5, 6);
        push_probe(CMD_LOOKUP, ones, lk_a, 5, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, ones, lk_c, 3, -50, 70, 6, 5);
        push_probe(CMD_LOOKUP, ones, lk_c, 3, 0, 0, 0, 0);
        push_probe(CMD_UPDATE, ones, lk_b, 9, 35, 35, -1, -1);
        push_probe(CMD_LOOKUP, ones, lk_b, 9, 0, 0, 0, 0);
        push_probe(CMD_LOOKUP, ones, lk_b, 127, 0, 0, 0, 0);
        wait_drained();

        // receiver holds off while requests keep coming
        hold_req = 1'b1;
        queue_random(40);
        while (!hold_done)
            @(negedge aclk);
        queue_random(110);
        wait_drained();

        snd_idle_pct = 45;
        rcv_idle_pct = 8;
        queue_random(150);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(150);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tstt_pkg.sv
hw/rtl/two_slot_transposition_table_core.sv
dv/tb_two_slot_transposition_table_core.sv
